[hdl/rsc_pkg.sv]
// Shared types, constants and helper functions of the radix string converter.
`timescale 1ns / 1ps

package rsc_pkg;

	// Sizes
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int BASE_W          = 6;
	localparam int DIGIT_W         = 6;
	localparam int MAX_DIGITS      = 32;
	localparam int DIGIT_AW        = $clog2(MAX_DIGITS);
	localparam int CNT_W           = $clog2(MAX_DIGITS + 1);
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 1'b1;

	// Register reset values and output base limits
	localparam logic [BASE_W-1:0] BASE_RESET    = 6'd10;
	localparam logic [BASE_W-1:0] OUT_BASE_MIN  = 6'd2;
	localparam logic [BASE_W-1:0] OUT_BASE_MAX  = 6'd36;

	// ASCII codes
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;
	localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIGIT    = 2'd1,
		ST_INVALID  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// Character classes
	typedef enum logic [1:0] {
		CK_DIGIT,
		CK_INVALID,
		CK_IGNORE
	} char_kind_t;

	typedef struct packed {
		char_kind_t          kind;
		logic [DIGIT_W-1:0]  digit;
	} char_class_t;

	// Beats
	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_out;
		status_t    status;
	} out_beat_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ACCUM,
		S_DIV_START,
		S_DIV_WAIT,
		S_READ,
		S_EMIT,
		S_ERROR
	} fsm_t;

	// Divider handshake
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Classify one ASCII character
	function automatic char_class_t char_class(input logic [7:0] c);
		char_class_t r;
		r.kind  = CK_IGNORE;
		r.digit = '0;
		if (c inside {[CH_0:CH_9]}) begin
			r.kind  = CK_DIGIT;
			r.digit = DIGIT_W'(c - CH_0);
		end else if (c inside {[CH_LA:CH_LZ]}) begin
			r.kind  = CK_DIGIT;
			r.digit = DIGIT_W'(c - CH_LA) + LETTER_BASE;
		end else if (c inside {[CH_UA:CH_UZ]}) begin
			r.kind  = CK_DIGIT;
			r.digit = DIGIT_W'(c - CH_UA) + LETTER_BASE;
		end else if (c inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
			r.kind  = CK_INVALID;
		end
		return r;
	endfunction

	// Digit value to uppercase ASCII
	function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [7:0] r;
		if (d < LETTER_BASE) r = CH_0 + 8'(d);
		else                 r = CH_UA + 8'(d - LETTER_BASE);
		return r;
	endfunction

endpackage

[hdl/radix_string_converter_unit.sv]
// Top level of the radix string converter: sequencer, accumulator and output stage.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid / in_stall     | in_data  {char_in, last_char}
//  out     | output    | out_valid / out_stall   | out_data {char_out, last_out, status}
//  cfg     | input     | cfg_we                  | cfg_index, cfg_data
//
// A character that is not last is accepted, then folded in by a multiply-add.
// The last character then runs, per output digit, a division in the shared bit-serial
// divider; each digit is then emitted by a digit RAM read and an output load.
// Reset clears the sequencer, the number state and the output valid; no clearing pass.
// A stalled output holds the sequencer in its emit or error state; input is stalled while
// a number is being converted or emitted.
`timescale 1ns / 1ps

module radix_string_converter_unit
	import rsc_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_beat_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_beat_t              out_data
);

	localparam int PW = VALUE_WIDTH + DIGIT_W + 1;

	// Character position codes
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_LATER  = 2'd2;

	fsm_t                   state_q, state_nx;
	logic [BASE_W-1:0]      in_base_q, out_base_q, base_eff;
	in_beat_t               in_q;
	logic [VALUE_WIDTH-1:0] accum_q, acc_nx, conv_q;
	logic [1:0]             pos_q, pos_nx;
	logic                   prefix_q, prefix_nx;
	status_t                err_q, err_nx, err_res_q;
	logic [CNT_W-1:0]       n_q, k_q;
	logic                   out_valid_q;
	out_beat_t              out_q;
	char_class_t            cc;
	logic [PW-1:0]          prod;
	logic                   in_fire, out_fire, can_load;
	logic                   out_load, ram_re;
	logic                   emit_last;
	logic [DIGIT_AW-1:0]    rd_addr;
	logic [DIGIT_W-1:0]     rd_digit;
	div_req_t               div_req;
	div_stat_t              div_stat;
	logic [VALUE_WIDTH-1:0] quot;
	logic [DIGIT_W-1:0]     rem;
	logic                   digits_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= BASE_RESET;
			out_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_BASE:  in_base_q  <= cfg_data;
				REG_OUT_BASE: out_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output base clamped to the supported range
	always_comb begin
		if (out_base_q < OUT_BASE_MIN)      base_eff = OUT_BASE_MIN;
		else if (out_base_q > OUT_BASE_MAX) base_eff = OUT_BASE_MAX;
		else                                base_eff = out_base_q;
	end

	// Handshakes
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid_q && !out_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign emit_last = ((k_q + 1'b1) == n_q);
	assign rd_addr   = DIGIT_AW'(n_q - k_q - 1'b1);
	assign digits_full = ((n_q + 1'b1) == CNT_W'(MAX_DIGITS));

	// Prefix rule, classification and multiply-add for one character
	always_comb begin
		cc        = char_class(in_q.char_in);
		prod      = PW'(accum_q) * PW'(in_base_q) + PW'(cc.digit);
		pos_nx    = (pos_q == POS_LATER) ? POS_LATER : pos_q + 2'd1;
		prefix_nx = prefix_q;
		err_nx    = err_q;
		acc_nx    = accum_q;
		if (pos_q == POS_FIRST && in_q.char_in == CH_0) begin
			prefix_nx = 1'b1;
		end else if (!(pos_q == POS_SECOND && prefix_q) && cc.kind != CK_IGNORE
				&& err_q == ST_OK) begin
			if (cc.kind == CK_INVALID)          err_nx = ST_INVALID;
			else if (cc.digit >= in_base_q)     err_nx = ST_DIGIT;
			else if (|prod[PW-1:VALUE_WIDTH])   err_nx = ST_OVERFLOW;
			else                                acc_nx = prod[VALUE_WIDTH-1:0];
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:      if (in_fire) state_nx = S_ACCUM;
			S_ACCUM: begin
				if (!in_q.last_char)      state_nx = S_IDLE;
				else if (err_nx != ST_OK) state_nx = S_ERROR;
				else                      state_nx = S_DIV_START;
			end
			S_DIV_START: state_nx = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_stat.done) begin
					if (quot == '0)       state_nx = S_READ;
					else if (digits_full) state_nx = S_ERROR;
					else                  state_nx = S_DIV_START;
				end
			end
			S_READ:      state_nx = S_EMIT;
			S_EMIT:      if (can_load) state_nx = emit_last ? S_IDLE : S_READ;
			S_ERROR:     if (can_load) state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall      = 1'b1;
		div_req.start = 1'b0;
		ram_re        = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE:      in_stall      = 1'b0;
			S_DIV_START: div_req.start = 1'b1;
			S_READ:      ram_re        = 1'b1;
			S_EMIT:      out_load      = can_load;
			S_ERROR:     out_load      = can_load;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nx;
	end

	// Input beat register
	always_ff @(posedge clk) begin
		if (in_fire) in_q <= in_data;
	end

	// Number state; cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			pos_q    <= POS_FIRST;
			prefix_q <= 1'b0;
			err_q    <= ST_OK;
		end else if (state_q == S_ACCUM) begin
			if (in_q.last_char) begin
				accum_q  <= '0;
				pos_q    <= POS_FIRST;
				prefix_q <= 1'b0;
				err_q    <= ST_OK;
			end else begin
				accum_q  <= acc_nx;
				pos_q    <= pos_nx;
				prefix_q <= prefix_nx;
				err_q    <= err_nx;
			end
		end
	end

	// Conversion value, error code of the result, digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= '0;
		end else begin
			if (state_q == S_ACCUM && in_q.last_char) n_q <= '0;
			if (state_q == S_DIV_WAIT && div_stat.done) begin
				n_q <= n_q + 1'b1;
				k_q <= '0;
			end
			if (state_q == S_EMIT && can_load) k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ACCUM && in_q.last_char) begin
			conv_q    <= acc_nx;
			err_res_q <= err_nx;
		end
		if (state_q == S_DIV_WAIT && div_stat.done) begin
			conv_q <= quot;
			if (quot != '0 && digits_full) err_res_q <= ST_OVERFLOW;
		end
	end

	// Shared divider
	rsc_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (conv_q),
		.divisor   (base_eff),
		.stat      (div_stat),
		.quotient  (quot),
		.remainder (rem)
	);

	// Digit buffer, least significant digit at address 0
	rsc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (state_q == S_DIV_WAIT && div_stat.done),
		.waddr (n_q[DIGIT_AW-1:0]),
		.wdata (rem),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (rd_digit)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_fire) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_ERROR) begin
				out_q.char_out <= '0;
				out_q.last_out <= 1'b1;
				out_q.status   <= err_res_q;
			end else begin
				out_q.char_out <= digit_to_ascii(rd_digit);
				out_q.last_out <= emit_last;
				out_q.status   <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.last_out && out_q.char_out == '0)
		else $error("error result not a single last beat");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond buffer depth");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == S_DIV_WAIT)
		else $error("divider running outside its wait state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(out_q) && out_valid_q)
		else $error("stalled output beat changed");

endmodule

[hdl/rsc_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module rsc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/rsc_divider.sv]
// Restoring divider by a narrow base, one quotient bit per cycle.
`timescale 1ns / 1ps

module rsc_divider
	import rsc_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_req_t               req,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [BASE_W-1:0]      divisor,
	output div_stat_t              stat,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [DIGIT_W-1:0]     remainder
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] work_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [BASE_W-1:0]      div_q;
	logic [DIGIT_W:0]       rem_sh;
	logic                   q_bit;
	logic [DIGIT_W-1:0]     rem_nx;

	// One trial subtraction per cycle
	always_comb begin
		rem_sh = {rem_q, work_q[VALUE_WIDTH-1]};
		q_bit  = (rem_sh >= (DIGIT_W+1)'(div_q));
		rem_nx = q_bit ? DIGIT_W'(rem_sh - (DIGIT_W+1)'(div_q)) : rem_sh[DIGIT_W-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(VALUE_WIDTH);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else             cnt_q  <= cnt_q - 1'b1;
		end
	end

	// Datapath: dividend shifts out at the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			work_q <= {work_q[VALUE_WIDTH-2:0], q_bit};
			rem_q  <= rem_nx;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

[tb/sv/rsc_checker.sv]
// Scoreboard for the radix string converter: mirrors the number state and checks each output beat.
`timescale 1ns / 1ps

module rsc_checker
	import rsc_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_beat_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_beat_t             out_data,
	output int                    fail_count,
	output int                    expected_left
);

	// Mirrored registers and number state
	logic [BASE_W-1:0] radix_in  = BASE_RESET;
	logic [BASE_W-1:0] radix_out = BASE_RESET;
	logic [63:0]       value_acc = '0;
	logic [1:0]        char_pos  = '0;
	logic              skip_next = 1'b0;
	status_t           num_err   = ST_OK;
	out_beat_t         digits_due[$];
	int                mismatches = 0;

	// Largest value the accumulator may hold
	function automatic logic [63:0] value_max();
		logic [63:0] m;
		if (VALUE_WIDTH >= 64) m = '1;
		else m = (64'd1 << VALUE_WIDTH) - 64'd1;
		return m;
	endfunction

	// Digit 0-35, -1 printable junk, -2 ignored
	function automatic int decode_char(input logic [7:0] c);
		int d;
		if (c >= CH_0 && c <= CH_9) d = int'(c - CH_0);
		else if (c >= CH_LA && c <= CH_LZ) d = int'(c - CH_LA) + 10;
		else if (c >= CH_UA && c <= CH_UZ) d = int'(c - CH_UA) + 10;
		else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) d = -1;
		else d = -2;
		return d;
	endfunction

	// Fold one character into the number; on the final one queue the digits or the error beat
	task automatic predict_char(input logic [7:0] c, input logic fin);
		logic [1:0]  pos;
		logic        take;
		int          d;
		int          n;
		logic [63:0] vmax;
		logic [63:0] base_o;
		logic [63:0] v;
		logic [5:0]  dig[MAX_DIGITS];
		out_beat_t   r;
		pos  = char_pos;
		take = 1'b1;
		vmax = value_max();
		if (char_pos < 2'd2) char_pos = char_pos + 2'd1;
		if (pos == 2'd0 && c == CH_0) begin
			skip_next = 1'b1;
			take      = 1'b0;
		end else if (pos == 2'd1 && skip_next) begin
			take = 1'b0;
		end
		if (take) begin
			d = decode_char(c);
			if (d == -2 || num_err != ST_OK) begin
				// nothing to do
			end else if (d == -1) begin
				num_err = ST_INVALID;
			end else if (d >= int'(radix_in)) begin
				num_err = ST_DIGIT;
			end else if (value_acc > (vmax - 64'(d)) / 64'(radix_in)) begin
				num_err = ST_OVERFLOW;
			end else begin
				value_acc = (value_acc * 64'(radix_in) + 64'(d)) & vmax;
			end
		end
		if (!fin) return;

		// out_base is clamped into 2..36
		if (radix_out < OUT_BASE_MIN) base_o = 64'(OUT_BASE_MIN);
		else if (radix_out > OUT_BASE_MAX) base_o = 64'(OUT_BASE_MAX);
		else base_o = 64'(radix_out);

		if (num_err == ST_OK) begin
			v = value_acc;
			n = 1;
			while (v >= base_o) begin
				v = v / base_o;
				n++;
			end
			if (n > MAX_DIGITS) num_err = ST_OVERFLOW;
		end

		if (num_err != ST_OK) begin
			r.char_out = 8'h00;
			r.last_out = 1'b1;
			r.status   = num_err;
			digits_due.push_back(r);
		end else begin
			v = value_acc;
			n = 0;
			do begin
				dig[n] = 6'(v % base_o);
				v = v / base_o;
				n++;
			end while (v != 0 && n < MAX_DIGITS);
			for (int k = n - 1; k >= 0; k--) begin
				if (dig[k] < 6'd10) r.char_out = CH_0 + 8'(dig[k]);
				else r.char_out = CH_UA + 8'(dig[k] - 6'd10);
				r.last_out = (k == 0);
				r.status   = ST_OK;
				digits_due.push_back(r);
			end
		end
		value_acc = '0;
		char_pos  = '0;
		skip_next = 1'b0;
		num_err   = ST_OK;
	endtask

	// Output beats are checked before the input beat of the same edge is folded in
	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			radix_in  = BASE_RESET;
			radix_out = BASE_RESET;
			value_acc = '0;
			char_pos  = '0;
			skip_next = 1'b0;
			num_err   = ST_OK;
			digits_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (digits_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, exp none, got char %02h last %0b st %0d",
						$time, out_data.char_out, out_data.last_out, out_data.status);
				end else begin
					want = digits_due.pop_front();
					if (out_data.char_out !== want.char_out ||
					    out_data.last_out !== want.last_out ||
					    out_data.status   !== want.status) begin
						mismatches++;
						$display({"%0t: mismatch, exp char %02h last %0b st %0d,",
							" got char %02h last %0b st %0d"},
							$time, want.char_out, want.last_out, want.status,
							out_data.char_out, out_data.last_out, out_data.status);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_IN_BASE) radix_in = cfg_data;
				else if (cfg_index == REG_OUT_BASE) radix_out = cfg_data;
			end
			if (in_valid && !in_stall) predict_char(in_data.char_in, in_data.last_char);
		end
		fail_count    <= mismatches;
		expected_left <= digits_due.size();
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top of the radix string converter: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
	import rsc_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int N_SET       = 8;
	localparam int SET_ITEMS   = 55;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_IN_BASE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_beat_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_beat_t             out_data;
	int                    fail_count;
	int                    expected_left;

	int                    items_sent   = 0;
	int                    tx_gap_pct   = 13;
	int                    rx_stall_pct = 69;
	int                    quiet_cycles = 0;
	logic [BASE_W-1:0]     cur_in_radix = BASE_RESET;

	// Base pairs per phase: extremes, clamped and unusual values
	logic [BASE_W-1:0] in_radix_set[N_SET]  = '{6'd2, 6'd36, 6'd16, 6'd1, 6'd0, 6'd63, 6'd7, 6'd36};
	logic [BASE_W-1:0] out_radix_set[N_SET] = '{6'd36, 6'd2, 6'd8, 6'd0, 6'd63, 6'd1, 6'd36, 6'd10};

	always #2 clk = ~clk;

	radix_string_converter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	rsc_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.expected_left(expected_left)
	);

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	// Watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One input beat; valid stays high afterwards so back-to-back beats need no toggle
	task automatic send_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= {c, fin};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (items_sent < 153) begin
			tx_gap_pct   = 13;
			rx_stall_pct = 69;
		end else if (items_sent < 306) begin
			tx_gap_pct   = 69;
			rx_stall_pct = 13;
		end else begin
			tx_gap_pct   = 0;
			rx_stall_pct = 0;
		end
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
	endtask

	// ASCII for a digit, letters in either case
	function automatic logic [7:0] digit_glyph(input int d);
		logic [7:0] c;
		if (d < 10) c = CH_0 + 8'(d);
		else if ($urandom_range(0, 1)) c = CH_UA + 8'(d - 10);
		else c = CH_LA + 8'(d - 10);
		return c;
	endfunction

	function automatic logic [7:0] unprintable();
		logic [7:0] c;
		if ($urandom_range(0, 1)) c = 8'($urandom_range(0, 31));
		else c = 8'($urandom_range(127, 255));
		return c;
	endfunction

	// One number: mostly well-formed digits, some broken by junk, some pure noise
	task automatic send_number();
		int         mode;
		int         len;
		int         lim;
		int         k;
		logic [7:0] c;
		mode = $urandom_range(0, 99);
		lim  = (cur_in_radix > 6'd36) ? 36 : int'(cur_in_radix);
		if (mode < 15 || lim == 0) begin
			len = $urandom_range(1, 10);
			for (k = 0; k < len; k++) send_char(8'($urandom_range(0, 255)), k == len - 1);
		end else begin
			if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 40);
			else len = $urandom_range(1, 8);
			// radix prefix such as 0x: second char is skipped whatever it is
			if ($urandom_range(0, 4) == 0) begin
				send_char(CH_0, 1'b0);
				send_char(8'($urandom_range(32, 126)), 1'b0);
			end
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 24) == 0) send_char(unprintable(), 1'b0);
				if (mode < 30 && $urandom_range(0, len - 1) == 0) begin
					if ($urandom_range(0, 1)) c = 8'($urandom_range(32, 126));
					else c = digit_glyph($urandom_range(0, 35));
				end else begin
					c = digit_glyph($urandom_range(0, lim - 1));
				end
				send_char(c, k == len - 1);
			end
		end
	endtask

	// Drop valid, then wait for the last result and let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_bases(input logic [BASE_W-1:0] radix_a, input logic [BASE_W-1:0] radix_b);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IN_BASE;
		cfg_data  <= radix_a;
		@(posedge clk);
		cfg_index <= REG_OUT_BASE;
		cfg_data  <= radix_b;
		@(posedge clk);
		cfg_we       <= 1'b0;
		cur_in_radix = radix_a;
	endtask

	// Stimulus
	initial begin
		int phase_end;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset bases: prefix only, prefix then a digit too big, junk then too-big digit
		send_text("0");
		send_text("0xF");
		send_text("5+A");
		// unprintables around a digit, first one taking the prefix position
		send_char(8'h00, 1'b0);
		send_char("7", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h7F, 1'b1);
		// empty number
		send_char(8'h1F, 1'b1);
		// one past the largest 32-bit value
		send_text("4294967296");

		for (int s = 0; s < N_SET; s++) begin
			wait_idle();
			write_bases(in_radix_set[s], out_radix_set[s]);
			phase_end = items_sent + SET_ITEMS;
			while (items_sent < phase_end) send_number();
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_left == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/rsc_pkg.sv
hdl/rsc_ram.sv
hdl/rsc_divider.sv
hdl/radix_string_converter_unit.sv
tb/sv/rsc_checker.sv
tb/sv/tb_top.sv
